/* sv/efd_pkg.sv */
package efd_pkg;

   // fixed field widths
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 7;
   localparam int unsigned CSR_INDEX_W = 2;

   // reset values of the control registers
   localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'd124;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'd92;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DELIMITER = 2'd0,
      REG_ESCAPE    = 2'd1
   } csr_index_type;

endpackage

/* sv/efd_ram.sv */
module efd_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/escaped_frame_decoder.sv */
// channel   ports                       direction  moves
// req       req_valid/req_ready         in         one received byte of the escaped stream
// rsp       rsp_valid/rsp_ready         out        one decoded byte with last/empty/length
// csr       csr_we/csr_index/csr_data   in         write of delimiter or escape byte
//
// Intake takes one byte per cycle while the output slot is free; data goes straight to RAM.
// A delimiter that ends a stored message switches to readout: one result per cycle from
// the RAM read port, no request taken until the last result has entered the output register.
// Empty messages go to the output register directly; overflowed messages give nothing.
// Synchronous reset clears fill count, flags and handshakes; the RAM needs no clearing.
// A stalled rsp side holds the RAM read data and stops further reads.
module escaped_frame_decoder #(
   parameter int unsigned BUFFER_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [efd_pkg::BYTE_W-1:0]       req_in_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [efd_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_last_byte,
   output logic                             rsp_empty_message,
   output logic [efd_pkg::LEN_W-1:0]        rsp_message_length,
   input  logic                             csr_we,
   input  logic [efd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [efd_pkg::BYTE_W-1:0]       csr_data
);
   import efd_pkg::*;

   localparam int unsigned ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

   typedef enum logic {
      ST_INTAKE,
      ST_REPLAY
   } state_type;

   state_type         state_ff, state_in;
   logic [BYTE_W-1:0] delim_ff, delim_in;
   logic [BYTE_W-1:0] escape_ff, escape_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic              overflow_ff, overflow_in;
   logic              esc_pend_ff, esc_pend_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              pend_last_ff, pend_last_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_empty_ff, out_empty_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;

   logic              req_fire;
   logic              out_free;
   logic              load_out;
   logic              issue_rd;
   logic              wr_en;
   logic [BYTE_W-1:0] rd_data;

   // output slot free this cycle
   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_INTAKE) && out_free;
   assign req_fire  = req_valid && req_ready;

   // readout pipeline: RAM data moves to the output register when the slot frees
   assign load_out = rd_pend_ff && out_free;
   assign issue_rd = (state_ff == ST_REPLAY) && (rd_idx_ff < len_ff) && (!rd_pend_ff || load_out);

   efd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff[ADDR_W-1:0]),
      .wr_data(req_in_byte),
      .rd_en  (issue_rd),
      .rd_addr(rd_idx_ff[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      delim_in     = delim_ff;
      escape_in    = escape_ff;
      fill_in      = fill_ff;
      overflow_in  = overflow_ff;
      esc_pend_in  = esc_pend_ff;
      len_in       = len_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = rd_pend_ff;
      pend_last_in = pend_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;
      out_len_in   = out_len_ff;
      wr_en        = 1'b0;

      // register writes
      if (csr_we) begin
         case (csr_index)
            REG_DELIMITER: delim_in  = csr_data;
            REG_ESCAPE:    escape_in = csr_data;
            default:       ;
         endcase
      end

      // intake of one byte
      if (req_fire) begin
         if (esc_pend_ff || (req_in_byte != escape_ff && req_in_byte != delim_ff)) begin
            esc_pend_in = 1'b0;
            if (!overflow_ff) begin
               if (fill_ff == DEPTH_LEN) begin
                  overflow_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + LEN_W'(1);
               end
            end
         end else if (req_in_byte == escape_ff) begin
            esc_pend_in = 1'b1;
         end else begin
            // unescaped delimiter ends the message
            fill_in = '0;
            if (overflow_ff) begin
               overflow_in = 1'b0;
            end else if (fill_ff == '0) begin
               out_valid_in = 1'b1;
               out_byte_in  = '0;
               out_last_in  = 1'b1;
               out_empty_in = 1'b1;
               out_len_in   = '0;
            end else begin
               len_in    = fill_ff;
               rd_idx_in = '0;
               state_in  = ST_REPLAY;
            end
         end
      end

      // readout into the output register
      if (load_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = rd_data;
         out_last_in  = pend_last_ff;
         out_empty_in = 1'b0;
         out_len_in   = len_ff;
         rd_pend_in   = 1'b0;
         if (pend_last_ff) begin
            state_in = ST_INTAKE;
         end
      end
      if (issue_rd) begin
         rd_pend_in   = 1'b1;
         pend_last_in = (rd_idx_ff == len_ff - LEN_W'(1));
         rd_idx_in    = rd_idx_ff + LEN_W'(1);
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INTAKE;
         delim_ff     <= DELIMITER_RESET;
         escape_ff    <= ESCAPE_RESET;
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         esc_pend_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delim_ff     <= delim_in;
         escape_ff    <= escape_in;
         fill_ff      <= fill_in;
         overflow_ff  <= overflow_in;
         esc_pend_ff  <= esc_pend_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      len_ff       <= len_in;
      rd_idx_ff    <= rd_idx_in;
      pend_last_ff <= pend_last_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
      out_len_ff   <= out_len_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_last_byte      = out_last_ff;
   assign rsp_empty_message  = out_empty_ff;
   assign rsp_message_length = out_len_ff;

endmodule

/* bench/tb_escaped_frame_decoder.sv */
`timescale 1ns / 100ps

module tb_escaped_frame_decoder;
   import efd_pkg::*;

   localparam int unsigned DEPTH = 64;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned DRAIN_CYCLES = 20;
   // index with no register behind it, the block must ignore writes to it
   localparam csr_index_type REG_UNUSED = csr_index_type'(2'd2);

   // one decoded byte as seen on the rsp channel
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              empty;
      logic [LEN_W-1:0]  len;
   } deframe_rsp_type;

   // tracks deframer state and holds the decoded bytes still to come out
   class deframe_scoreboard;
      logic [BYTE_W-1:0] delimiter;
      logic [BYTE_W-1:0] escape;
      logic [BYTE_W-1:0] msg_buf [DEPTH];
      int unsigned       fill;
      bit                overflow;
      bit                escaped;
      deframe_rsp_type   expected_bytes [$];
      int unsigned       mismatches;

      function new();
         delimiter  = DELIMITER_RESET;
         escape     = ESCAPE_RESET;
         fill       = 0;
         overflow   = 1'b0;
         escaped    = 1'b0;
         mismatches = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [BYTE_W-1:0] value);
         case (idx)
            REG_DELIMITER: delimiter = value;
            REG_ESCAPE:    escape = value;
            default: ;
         endcase
      endfunction

      // data byte into the buffer, or flag overflow once it is full
      function void keep_byte(logic [BYTE_W-1:0] value);
         if (overflow) begin
            return;
         end
         if (fill >= DEPTH) begin
            overflow = 1'b1;
            return;
         end
         msg_buf[fill] = value;
         fill++;
      endfunction

      function void note_request(logic [BYTE_W-1:0] value);
         deframe_rsp_type item;
         if (escaped) begin
            keep_byte(value);
            escaped = 1'b0;
         end else if (value == escape) begin
            escaped = 1'b1;
         end else if (value == delimiter) begin
            // end of message: replay, report empty, or drop after overflow
            if (overflow) begin
               overflow = 1'b0;
            end else if (fill == 0) begin
               item = '{data: '0, last: 1'b1, empty: 1'b1, len: '0};
               expected_bytes.push_back(item);
            end else begin
               for (int k = 0; k < fill; k++) begin
                  item.data  = msg_buf[k];
                  item.last  = (k + 1 == fill);
                  item.empty = 1'b0;
                  item.len   = LEN_W'(fill);
                  expected_bytes.push_back(item);
               end
            end
            fill = 0;
         end else begin
            keep_byte(value);
         end
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      function void check_response(deframe_rsp_type got);
         deframe_rsp_type want;
         if (expected_bytes.size() == 0) begin
            $error("unexpected response: out_byte %0d last %0d empty %0d length %0d",
                   got.data, got.last, got.empty, got.len);
            mismatches++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.data !== want.data) begin
            $error("out_byte: expected %0d, actual %0d", want.data, got.data);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last_byte: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
         end
         if (got.empty !== want.empty) begin
            $error("empty_message: expected %0d, actual %0d", want.empty, got.empty);
            mismatches++;
         end
         if (got.len !== want.len) begin
            $error("message_length: expected %0d, actual %0d", want.len, got.len);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_in_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic                 rsp_last_byte;
   logic                 rsp_empty_message;
   logic [LEN_W-1:0]     rsp_message_length;
   logic                 csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_DELIMITER;
   logic [BYTE_W-1:0]    csr_data = '0;

   deframe_scoreboard deframe_sb = new();
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned bytes_sent = 0;

   escaped_frame_decoder #(
      .BUFFER_DEPTH(DEPTH)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_empty_message  (rsp_empty_message),
      .rsp_message_length (rsp_message_length),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      #5ms;
      $display("tb_escaped_frame_decoder: FAIL");
      $finish;
   end

   // response side: check accepted bytes, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            deframe_sb.check_response(deframe_rsp_type'{data: rsp_out_byte,
                                                         last: rsp_last_byte,
                                                         empty: rsp_empty_message,
                                                         len: rsp_message_length});
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // one request byte, with random gaps before it
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (!req_ready);
      deframe_sb.note_request(value);
      bytes_sent++;
   endtask

   // hold off requests until every decoded byte has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (deframe_sb.pending() != 0);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      deframe_sb.write_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // payload byte biased toward the two control values
   function automatic logic [BYTE_W-1:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 12) begin
         return deframe_sb.delimiter;
      end else if (roll < 24) begin
         return deframe_sb.escape;
      end
      return BYTE_W'($urandom_range(255));
   endfunction

   // well-formed message: control values and some plain bytes get escaped
   task automatic send_frame(input int unsigned len, input bit terminate);
      logic [BYTE_W-1:0] value;
      for (int i = 0; i < len; i++) begin
         value = pick_byte();
         if (value == deframe_sb.delimiter || value == deframe_sb.escape ||
             $urandom_range(19) == 0) begin
            send_byte(deframe_sb.escape);
         end
         send_byte(value);
      end
      if (terminate) begin
         send_byte(deframe_sb.delimiter);
      end
   endtask

   // long message of counting bytes, only control values escaped
   task automatic send_plain_frame(input int unsigned len);
      logic [BYTE_W-1:0] value;
      for (int i = 0; i < len; i++) begin
         value = BYTE_W'(i);
         if (value == deframe_sb.delimiter || value == deframe_sb.escape) begin
            send_byte(deframe_sb.escape);
         end
         send_byte(value);
      end
      send_byte(deframe_sb.delimiter);
   endtask

   // mostly short messages, some noise
   task automatic random_traffic(input int unsigned count);
      int unsigned start;
      int unsigned roll;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         roll = $urandom_range(99);
         if (roll < 76) begin
            send_frame($urandom_range(12), 1'b1);
         end else if (roll < 88) begin
            repeat ($urandom_range(1, 6)) send_byte(pick_byte());
         end else if (roll < 94) begin
            send_frame($urandom_range(1, 8), 1'b0);
         end else begin
            // dangling escape right before the delimiter
            send_frame($urandom_range(4), 1'b0);
            send_byte(deframe_sb.escape);
            send_byte(deframe_sb.delimiter);
         end
         if ($urandom_range(19) == 0) begin
            wait_drained();
         end
      end
   endtask

   task automatic run_phase(input logic [BYTE_W-1:0] delim, input logic [BYTE_W-1:0] esc,
                            input int unsigned idle, input int unsigned stall,
                            input int unsigned count);
      write_csr(REG_DELIMITER, delim);
      write_csr(REG_ESCAPE, esc);
      send_idle_pct = idle;
      stall_pct     = stall;
      random_traffic(count);
   endtask

   // main sequence
   initial begin
      do @(posedge clock); while (reset);

      // directed: empty message, edge values, escaped control bytes
      send_byte(deframe_sb.delimiter);
      send_byte(8'h00);
      send_byte(deframe_sb.delimiter);
      send_byte(8'hff);
      send_byte(8'h41);
      send_byte(deframe_sb.delimiter);
      send_byte(deframe_sb.escape);
      send_byte(deframe_sb.delimiter);
      send_byte(deframe_sb.delimiter);
      send_byte(deframe_sb.escape);
      send_byte(deframe_sb.escape);
      send_byte(deframe_sb.delimiter);
      send_byte(deframe_sb.escape);
      send_byte(8'h41);
      send_byte(deframe_sb.delimiter);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h55);
      send_byte(8'haa);
      send_byte(deframe_sb.delimiter);
      write_csr(REG_UNUSED, 8'h41);
      send_byte(8'h41);
      send_byte(deframe_sb.delimiter);

      // random phases over register settings and idle patterns
      run_phase(DELIMITER_RESET, ESCAPE_RESET, 0, 0, 8);
      // one byte past the buffer size under sender gaps
      run_phase(8'h00, 8'hff, 63, 0, 6);
      send_plain_frame(DEPTH + 1);
      // a full buffer replayed under receiver stalls
      run_phase(8'hff, 8'h00, 0, 63, 6);
      send_plain_frame(DEPTH);
      // delimiter equal to escape: nothing ever ends
      run_phase(8'h00, 8'h00, 14, 14, 6);
      run_phase(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 0, 0, 6);
      run_phase(DELIMITER_RESET, ESCAPE_RESET, 14, 14, 8);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (deframe_sb.mismatches == 0) begin
         $display("tb_escaped_frame_decoder: PASS");
      end else begin
         $display("tb_escaped_frame_decoder: FAIL");
      end
      $finish;
   end

endmodule
